// File: hdl/bffa_pkg.sv
// ============================================================================
// bffa_pkg
// Shared types and constants of the bitmap first-fit allocator: field widths,
// operation codes, controller states and the controller/datapath link.
// ============================================================================
package bffa_pkg;

   // field widths
   localparam int OP_W    = 2;
   localparam int START_W = 10;
   localparam int LEN_W   = 11;
   localparam int POS_W   = 10;
   localparam int ACT_W   = 8;
   localparam int BYTE_W  = 8;

   // bit layout of one map byte: unit 0 of a byte sits in the msb
   localparam int BYTE_SHIFT = 3;
   localparam int TOP_BIT    = 7;

   // active byte count after reset
   localparam logic [ACT_W-1:0] ACT_RESET = 8'd128;

   // operation codes
   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_SEARCH = 2'd0;
   localparam op_type OP_ALLOC  = 2'd1;
   localparam op_type OP_FREE   = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_RUN,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // latch the request and set up the walk
      logic read;     // read the byte at the walk address
      logic proc;     // work on the byte read last cycle
      logic clear;    // write zero at the walk address
      logic finish;   // load the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;       // request touches no byte
      logic scan_done;   // byte in work is the last one, or search hit
      logic clear_last;  // clearing pass is at the top byte
      logic out_busy;    // response register still holds an untaken response
   } status_type;

endpackage

// File: hdl/bffa_if.sv
// ============================================================================
// bffa_if
// Valid/ready channels of the bitmap first-fit allocator: request, response
// and register write.
// ============================================================================
interface bffa_req_if;
   import bffa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [START_W-1:0]   start_index;
   logic [LEN_W-1:0]     run_length;

   modport source (output valid, output op, output start_index, output run_length,
                   input ready);
   modport sink   (input valid, input op, input start_index, input run_length,
                   output ready);
endinterface

interface bffa_rsp_if;
   import bffa_pkg::*;
   logic               valid;
   logic               ready;
   logic               found;
   logic [POS_W-1:0]   position;

   modport source (output valid, output found, output position, input ready);
   modport sink   (input valid, input found, input position, output ready);
endinterface

interface bffa_csr_if;
   import bffa_pkg::*;
   logic               valid;
   logic               ready;
   logic [ACT_W-1:0]   active_bytes;

   modport source (output valid, output active_bytes, input ready);
   modport sink   (input valid, input active_bytes, output ready);
endinterface

// File: hdl/bffa_ctrl.sv
// ============================================================================
// bffa_ctrl
// Controller of the allocator: clearing pass, request accept, byte walk
// sequencing and response hand-off.
// ============================================================================
module bffa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output bffa_pkg::cmd_type      cmd,
   input  bffa_pkg::status_type   status
);
   import bffa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.read = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.proc = 1'b1;
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.read = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// File: hdl/bffa_dp.sv
// ============================================================================
// bffa_dp
// Datapath of the allocator: bitmap memory, walk address, run counter,
// range masking, active size register and response register.
// ============================================================================
module bffa_dp #(
   parameter int MAP_BYTES = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bffa_pkg::cmd_type              cmd,
   output bffa_pkg::status_type           status,
   input  logic [bffa_pkg::OP_W-1:0]      req_op,
   input  logic [bffa_pkg::START_W-1:0]   req_start_index,
   input  logic [bffa_pkg::LEN_W-1:0]     req_run_length,
   input  logic                           csr_valid,
   input  logic [bffa_pkg::ACT_W-1:0]     csr_active_bytes,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_found,
   output logic [bffa_pkg::POS_W-1:0]     rsp_position
);
   import bffa_pkg::*;

   localparam int AW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int BW  = $clog2(MAP_BYTES + 1);
   localparam int UW  = BW + BYTE_SHIFT;
   localparam int EW  = (UW > LEN_W + 1) ? UW : LEN_W + 1;
   localparam int IW  = AW + BYTE_SHIFT;
   localparam int PW  = (IW > POS_W) ? IW : POS_W;
   localparam logic [AW-1:0] ADDR_TOP = AW'(MAP_BYTES - 1);

   logic [BYTE_W-1:0] mem [MAP_BYTES];

   logic [ACT_W-1:0]  active_ff, active_in;
   op_type            op_ff, op_in;
   logic [EW-1:0]     start_ff, start_in;
   logic [EW-1:0]     end_ff, end_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              empty_ff, empty_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [AW-1:0]     last_ff, last_in;
   logic [AW-1:0]     proc_ff, proc_in;
   logic [BYTE_W-1:0] rdata_ff;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic              hit_ff, hit_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;

   // request decode
   logic [EW-1:0]     act_bytes, units, start_e, len_e, end_raw, end_c;
   logic              empty_load;
   logic [AW-1:0]     first_load, last_load;

   // byte work
   logic [LEN_W-1:0]  cnt_v;
   logic              hit_v;
   logic [POS_W-1:0]  pos_v;
   logic [BYTE_W-1:0] new_byte;
   logic [IW-1:0]     unit_idx;
   logic              in_rng;
   logic              is_update;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;

   always_comb begin
      act_bytes = (EW'(active_ff) > EW'(MAP_BYTES)) ? EW'(MAP_BYTES) : EW'(active_ff);
      units     = act_bytes << BYTE_SHIFT;
      start_e   = EW'(req_start_index);
      len_e     = EW'(req_run_length);
      end_raw   = start_e + len_e;
      end_c     = (end_raw > units) ? units : end_raw;
      unique case (req_op)
         OP_SEARCH: begin
            empty_load = (len_e == '0) || (len_e > units);
            first_load = '0;
            last_load  = AW'(act_bytes - EW'(1));
         end
         OP_ALLOC, OP_FREE: begin
            empty_load = (start_e >= end_c);
            first_load = AW'(start_e >> BYTE_SHIFT);
            last_load  = AW'((end_c - EW'(1)) >> BYTE_SHIFT);
         end
         default: begin
            empty_load = 1'b1;
            first_load = '0;
            last_load  = '0;
         end
      endcase
   end

   // one byte of the walk, msb first
   always_comb begin
      cnt_v     = count_ff;
      hit_v     = hit_ff;
      pos_v     = pos_ff;
      new_byte  = rdata_ff;
      unit_idx  = '0;
      in_rng    = 1'b0;
      is_update = (op_ff == OP_ALLOC) || (op_ff == OP_FREE);
      for (int b = 0; b <= TOP_BIT; b++) begin
         unit_idx = {proc_ff, 3'(b)};
         if (!hit_v) begin
            if (rdata_ff[TOP_BIT - b]) begin
               cnt_v = '0;
            end else begin
               cnt_v = cnt_v + LEN_W'(1);
            end
            if (cnt_v == len_ff) begin
               hit_v = 1'b1;
               pos_v = POS_W'(PW'(unit_idx)) + POS_W'(1) - POS_W'(len_ff);
            end
         end
         in_rng = (EW'(unit_idx) >= start_ff) && (EW'(unit_idx) < end_ff);
         if (in_rng) begin
            new_byte[TOP_BIT - b] = (op_ff == OP_ALLOC);
         end
      end
   end

   always_comb begin
      active_in    = csr_valid ? csr_active_bytes : active_ff;
      op_in        = op_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      len_in       = len_ff;
      empty_in     = empty_ff;
      addr_in      = addr_ff;
      last_in      = last_ff;
      proc_in      = proc_ff;
      count_in     = count_ff;
      hit_in       = hit_ff;
      pos_in       = pos_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.load) begin
         op_in    = req_op;
         start_in = start_e;
         end_in   = end_c;
         len_in   = req_run_length;
         empty_in = empty_load;
         addr_in  = first_load;
         last_in  = last_load;
         count_in = '0;
         hit_in   = 1'b0;
         pos_in   = '0;
      end
      if (cmd.read || cmd.clear) begin
         addr_in = addr_ff + AW'(1);
      end
      if (cmd.read) begin
         proc_in = addr_ff;
      end
      if (cmd.proc && (op_ff == OP_SEARCH)) begin
         count_in = cnt_v;
         hit_in   = hit_v;
         pos_in   = pos_v;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = hit_ff;
         rsp_pos_in   = hit_ff ? pos_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ACT_RESET;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      len_ff       <= len_in;
      empty_ff     <= empty_in;
      last_ff      <= last_in;
      proc_ff      <= proc_in;
      count_ff     <= count_in;
      hit_ff       <= hit_in;
      pos_ff       <= pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   // bitmap memory: one write port, one registered read port
   assign mem_we    = cmd.clear || (cmd.proc && is_update);
   assign mem_waddr = cmd.clear ? addr_ff : proc_ff;
   assign mem_wdata = cmd.clear ? '0 : new_byte;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rdata_ff <= mem[addr_ff];
      end
   end

   always_comb begin
      status.empty      = empty_ff;
      status.scan_done  = (proc_ff == last_ff) || ((op_ff == OP_SEARCH) && hit_v);
      status.clear_last = (addr_ff == ADDR_TOP);
      status.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_pos_ff;

endmodule

// File: hdl/bitmap_first_fit_allocator.sv
// ============================================================================
// bitmap_first_fit_allocator
// Allocation bitmap with first-fit free run search and range allocate/free.
// ============================================================================
// The map holds MAP_BYTES bytes, one bit per unit, 1 meaning allocated; unit
// 0 is the msb of byte 0. Only the first min(active_bytes, MAP_BYTES) bytes
// take part. A search request (op 0) answers the lowest start of a free run of
// run_length units, or found 0 / position 0 when there is none, the length is
// zero or the length exceeds the active size. An allocate (op 1) or free (op
// 2) request sets or clears units start_index .. start_index+run_length-1,
// dropping units past the active end, and answers found 0 / position 0, as
// does op 3. Every request gets exactly one response. One request is worked at
// a time; the walk reads one map byte per cycle through the single read port
// of the bitmap memory. The bytes walked are, for a search, the bytes up
// to and including the one where the run completes (all active bytes when
// none does), for an update the bytes the clipped range touches, and none for
// a request that touches nothing. A new request can be accepted while the
// previous response still waits in the response register. After reset a
// clearing pass writes the map to all free, during which no request is
// accepted; register writes are always taken and must only come while the
// block is idle.
module bitmap_first_fit_allocator #(
   parameter int MAP_BYTES = 128
) (
   input  logic            clock,
   input  logic            reset,
   bffa_req_if.sink        req_if,
   bffa_rsp_if.source      rsp_if,
   bffa_csr_if.sink        csr_if
);
   import bffa_pkg::*;

   cmd_type    cmd;
   status_type status;

   // the size register is always writable
   assign csr_if.ready = 1'b1;

   // sequencing: clearing pass, accept, walk, response hand-off
   bffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // bitmap memory, run counter, range masks and response register
   bffa_dp #(
      .MAP_BYTES (MAP_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_if.op),
      .req_start_index  (req_if.start_index),
      .req_run_length   (req_if.run_length),
      .csr_valid        (csr_if.valid),
      .csr_active_bytes (csr_if.active_bytes),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_found        (rsp_if.found),
      .rsp_position     (rsp_if.position)
   );

endmodule
